// ===== rtl/core/pofq_pkg.sv =====
`default_nettype none

package pofq_pkg;

  // command codes
  localparam logic [1:0] CMD_PUSH  = 2'd0;
  localparam logic [1:0] CMD_POP   = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  // message types
  localparam logic [2:0] MSG_ERROR   = 3'd0;
  localparam logic [2:0] MSG_CONTROL = 3'd1;
  localparam logic [2:0] MSG_STATE   = 3'd2;
  localparam logic [2:0] MSG_MAP     = 3'd3;

  // popped frame source
  localparam logic [1:0] CLS_URGENT   = 2'd0;
  localparam logic [1:0] CLS_RELIABLE = 2'd1;
  localparam logic [1:0] CLS_STATE    = 2'd2;
  localparam logic [1:0] CLS_MAP      = 2'd3;

  // fixed field widths
  localparam int CAP_W = 5;
  localparam int OCC_FIELD_W = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // result flags that travel from the control unit to the result stage
  typedef struct packed {
    logic                   accepted;
    logic                   slot_overwrite;
    logic                   fatal;
    logic                   popped_valid;
    logic [1:0]             popped_class;
    logic                   from_mem;
    logic [OCC_FIELD_W-1:0] occupancy;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/core/pofq_mem.sv =====
`default_nettype none

module pofq_mem #(
  parameter int TAG_BITS = 32,
  parameter int ADDR_W = 5
) (
  input  wire logic                clk,
  input  wire logic                wr_en,
  input  wire logic [ADDR_W-1:0]   wr_addr,
  input  wire logic [TAG_BITS-1:0] wr_data,
  input  wire logic                rd_en,
  input  wire logic [ADDR_W-1:0]   rd_addr,
  output logic      [TAG_BITS-1:0] rd_data
);

  logic [TAG_BITS-1:0] mem [2**ADDR_W];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port, holds its data until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/pofq_ctrl.sv =====
`default_nettype none

module pofq_ctrl
  import pofq_pkg::*;
#(
  parameter int FIFO_DEPTH = 16,
  parameter int TAG_BITS = 32,
  parameter int PTR_W = 4,
  parameter int ADDR_W = 5
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_write,
  input  wire logic [CAP_W-1:0]    cfg_data,
  input  wire logic                accept,
  input  wire logic [1:0]          command,
  input  wire logic [2:0]          msg_type,
  input  wire logic                hold_or_reset,
  input  wire logic [TAG_BITS-1:0] frame_tag,
  output logic                     mem_wr_en,
  output logic      [ADDR_W-1:0]   mem_wr_addr,
  output logic      [TAG_BITS-1:0] mem_wr_data,
  output logic                     mem_rd_en,
  output logic      [ADDR_W-1:0]   mem_rd_addr,
  output res_t                     res,
  output logic      [TAG_BITS-1:0] slot_tag
);

  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam int CMP_W = (SUM_W > CAP_W) ? SUM_W : CAP_W;
  localparam int OCC_W = (CNT_W + 2 > OCC_FIELD_W) ? CNT_W + 2 : OCC_FIELD_W;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
  localparam logic [CMP_W-1:0] DEPTH_CMP = CMP_W'(FIFO_DEPTH);
  localparam logic [SUM_W-1:0] DEPTH_SUM = SUM_W'(FIFO_DEPTH);

  logic [CAP_W-1:0]    capacity;
  logic [CNT_W-1:0]    ucount, ucount_next;
  logic [CNT_W-1:0]    rcount, rcount_next;
  logic [PTR_W-1:0]    urd, urd_next;
  logic [PTR_W-1:0]    rrd, rrd_next;
  logic                st_valid, st_valid_next;
  logic [TAG_BITS-1:0] st_tag, st_tag_next;
  logic                mp_valid, mp_valid_next;
  logic [TAG_BITS-1:0] mp_tag, mp_tag_next;

  logic [CMP_W-1:0]    total;
  logic                full;
  logic                urgent;
  logic [SUM_W-1:0]    wr_sum;
  logic [SUM_W-1:0]    wr_wrap;
  logic [OCC_W-1:0]    occ_sum;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
  endfunction

  // push classification and shared capacity check
  assign urgent = (msg_type == MSG_ERROR) || ((msg_type == MSG_CONTROL) && hold_or_reset);
  assign total  = CMP_W'(ucount) + CMP_W'(rcount);
  assign full   = (total >= CMP_W'(capacity)) || (total >= DEPTH_CMP);

  // tail slot of the chosen fifo
  assign wr_sum  = urgent ? (SUM_W'(urd) + SUM_W'(ucount)) : (SUM_W'(rrd) + SUM_W'(rcount));
  assign wr_wrap = (wr_sum >= DEPTH_SUM) ? wr_sum - DEPTH_SUM : wr_sum;

  // next state and result of one word
  always_comb begin
    ucount_next   = ucount;
    rcount_next   = rcount;
    urd_next      = urd;
    rrd_next      = rrd;
    st_valid_next = st_valid;
    st_tag_next   = st_tag;
    mp_valid_next = mp_valid;
    mp_tag_next   = mp_tag;
    mem_wr_en     = 1'b0;
    mem_wr_addr   = {!urgent, wr_wrap[PTR_W-1:0]};
    mem_wr_data   = frame_tag;
    mem_rd_en     = 1'b0;
    mem_rd_addr   = {1'b0, urd};
    res           = '0;
    slot_tag      = '0;
    if (accept) begin
      unique case (command)
        CMD_PUSH: begin
          if (msg_type == MSG_STATE) begin
            res.slot_overwrite = st_valid;
            res.accepted       = 1'b1;
            st_valid_next      = 1'b1;
            st_tag_next        = frame_tag;
          end else if (msg_type == MSG_MAP) begin
            res.slot_overwrite = mp_valid;
            res.accepted       = 1'b1;
            mp_valid_next      = 1'b1;
            mp_tag_next        = frame_tag;
          end else if (full) begin
            res.fatal = 1'b1;
          end else begin
            res.accepted = 1'b1;
            mem_wr_en    = 1'b1;
            if (urgent) begin
              ucount_next = ucount + CNT_W'(1);
            end else begin
              rcount_next = rcount + CNT_W'(1);
            end
          end
        end
        CMD_POP: begin
          if (ucount != '0) begin
            res.popped_valid = 1'b1;
            res.popped_class = CLS_URGENT;
            res.from_mem     = 1'b1;
            mem_rd_en        = 1'b1;
            mem_rd_addr      = {1'b0, urd};
            urd_next         = ptr_inc(urd);
            ucount_next      = ucount - CNT_W'(1);
          end else if (rcount != '0) begin
            res.popped_valid = 1'b1;
            res.popped_class = CLS_RELIABLE;
            res.from_mem     = 1'b1;
            mem_rd_en        = 1'b1;
            mem_rd_addr      = {1'b1, rrd};
            rrd_next         = ptr_inc(rrd);
            rcount_next      = rcount - CNT_W'(1);
          end else if (st_valid) begin
            res.popped_valid = 1'b1;
            res.popped_class = CLS_STATE;
            slot_tag         = st_tag;
            st_valid_next    = 1'b0;
          end else if (mp_valid) begin
            res.popped_valid = 1'b1;
            res.popped_class = CLS_MAP;
            slot_tag         = mp_tag;
            mp_valid_next    = 1'b0;
          end
        end
        CMD_CLEAR: begin
          ucount_next   = '0;
          rcount_next   = '0;
          urd_next      = '0;
          rrd_next      = '0;
          st_valid_next = 1'b0;
          mp_valid_next = 1'b0;
        end
        default: begin
        end
      endcase
    end
    occ_sum = OCC_W'(ucount_next) + OCC_W'(rcount_next)
            + OCC_W'(st_valid_next) + OCC_W'(mp_valid_next);
    res.occupancy = occ_sum[OCC_FIELD_W-1:0];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
      ucount   <= '0;
      rcount   <= '0;
      urd      <= '0;
      rrd      <= '0;
      st_valid <= 1'b0;
      mp_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        capacity <= cfg_data;
      end
      ucount   <= ucount_next;
      rcount   <= rcount_next;
      urd      <= urd_next;
      rrd      <= rrd_next;
      st_valid <= st_valid_next;
      mp_valid <= mp_valid_next;
    end
  end

  // slot contents
  always_ff @(posedge clk) begin
    st_tag <= st_tag_next;
    mp_tag <= mp_tag_next;
  end

endmodule

`default_nettype wire

// ===== rtl/core/priority_outbound_frame_queue.sv =====
`default_nettype none

// Strict-priority outbound frame queue.
// Input channel (in_valid / in_stall) carries one command word: push a frame
// handle, pop the next frame, or clear everything. Output channel
// (out_valid / out_stall) returns exactly one result word per command.
// Urgent and reliable handles live in one synchronous tag memory split into
// two ring buffers; the state and map latest-value slots are registers.
// After its command is accepted, a result passes through the read stage, where
// the tag memory read lands, and then through the output register.
// Throughput: one command per cycle while the output is drained; the memory
// read stage and the output register form a two-deep pipeline.
// When the receiver stalls, the result holds and the pipeline fills; input
// stalls once both stages hold a word.
// cfg_write loads the shared fifo capacity from cfg_data; write it only while
// the queue is idle.
// Synchronous reset empties both fifos and slots, sets capacity to 16 and
// drops any result in flight. No clearing pass is needed.
module priority_outbound_frame_queue
  import pofq_pkg::*;
#(
  parameter int FIFO_DEPTH = 16,
  parameter int TAG_BITS = 32
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_write,
  input  wire logic [CAP_W-1:0]    cfg_data,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [1:0]          command,
  input  wire logic [2:0]          msg_type,
  input  wire logic                hold_or_reset,
  input  wire logic [TAG_BITS-1:0] frame_tag,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic                     accepted,
  output logic                     slot_overwrite,
  output logic                     fatal,
  output logic                     popped_valid,
  output logic      [TAG_BITS-1:0] popped_tag,
  output logic      [1:0]          popped_class,
  output logic      [OCC_FIELD_W-1:0] occupancy
);

  localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int ADDR_W = PTR_W + 1;

  logic                accept;
  logic                mem_wr_en;
  logic [ADDR_W-1:0]   mem_wr_addr;
  logic [TAG_BITS-1:0] mem_wr_data;
  logic                mem_rd_en;
  logic [ADDR_W-1:0]   mem_rd_addr;
  logic [TAG_BITS-1:0] mem_rd_data;
  res_t                res;
  logic [TAG_BITS-1:0] slot_tag;

  logic                s1_valid;
  res_t                s1_res;
  logic [TAG_BITS-1:0] s1_tag;
  logic                s1_move;
  res_t                out_res;

  // handshake: read stage advances when output register is free or drained
  assign s1_move  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_move;
  assign accept   = in_valid && !in_stall;

  pofq_ctrl #(
    .FIFO_DEPTH (FIFO_DEPTH),
    .TAG_BITS   (TAG_BITS),
    .PTR_W      (PTR_W),
    .ADDR_W     (ADDR_W)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data),
    .accept        (accept),
    .command       (command),
    .msg_type      (msg_type),
    .hold_or_reset (hold_or_reset),
    .frame_tag     (frame_tag),
    .mem_wr_en     (mem_wr_en),
    .mem_wr_addr   (mem_wr_addr),
    .mem_wr_data   (mem_wr_data),
    .mem_rd_en     (mem_rd_en),
    .mem_rd_addr   (mem_rd_addr),
    .res           (res),
    .slot_tag      (slot_tag)
  );

  pofq_mem #(
    .TAG_BITS (TAG_BITS),
    .ADDR_W   (ADDR_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // read stage and output register valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // read stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_res <= res;
      s1_tag <= slot_tag;
    end
  end

  // output register, memory data joins here
  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_res    <= s1_res;
      popped_tag <= s1_res.from_mem ? mem_rd_data : s1_tag;
    end
  end

  assign accepted       = out_res.accepted;
  assign slot_overwrite = out_res.slot_overwrite;
  assign fatal          = out_res.fatal;
  assign popped_valid   = out_res.popped_valid;
  assign popped_class   = out_res.popped_class;
  assign occupancy      = out_res.occupancy;

`ifndef SYNTHESIS
  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (accept && command == CMD_CLEAR) |=> (s1_valid && s1_res.occupancy == '0))
    else $error("clear left frames behind");

  a_push_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(accepted && fatal))
    else $error("push both stored and refused");

  a_pop_no_push_flags: assert property (@(posedge clk) disable iff (rst)
    (out_valid && popped_valid) |-> (!accepted && !fatal && !slot_overwrite))
    else $error("pop result carries push flags");

  a_mem_read_only_pop: assert property (@(posedge clk) disable iff (rst)
    mem_rd_en |-> (accept && command == CMD_POP))
    else $error("tag memory read outside a pop");
`endif

endmodule

`default_nettype wire

// ===== test/tb_priority_outbound_frame_queue.sv =====
`default_nettype none

module tb_priority_outbound_frame_queue;
  import pofq_pkg::*;

  localparam int DEPTH = 16;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam logic [1:0] CMD_SPARE = 2'd3;
  localparam logic [2:0] MSG_OTHER = 3'd4;

  typedef struct packed {
    logic [1:0]  command;
    logic [2:0]  msg_type;
    logic        hold_or_reset;
    logic [31:0] frame_tag;
  } frame_req_t;

  typedef struct packed {
    logic        accepted;
    logic        slot_overwrite;
    logic        fatal;
    logic        popped_valid;
    logic [31:0] popped_tag;
    logic [1:0]  popped_class;
    logic [4:0]  occupancy;
  } frame_resp_t;

  // dut signals
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CAP_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] command = '0;
  logic [2:0] msg_type = '0;
  logic hold_or_reset = 1'b0;
  logic [31:0] frame_tag = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic accepted;
  logic slot_overwrite;
  logic fatal;
  logic popped_valid;
  logic [31:0] popped_tag;
  logic [1:0] popped_class;
  logic [OCC_FIELD_W-1:0] occupancy;

  // queue model state
  logic [31:0] urg_tags[$];
  logic [31:0] rel_tags[$];
  logic state_held = 1'b0;
  logic [31:0] state_value = '0;
  logic map_held = 1'b0;
  logic [31:0] map_value = '0;
  int fifo_limit = 16;

  // stimulus and scoreboard
  frame_req_t cmd_pending[$];
  frame_req_t cmd_cur;
  frame_resp_t resp_expected[$];
  int send_gap = 0;
  int send_quiet = 0;
  int stall_left = 0;
  int stall_quiet = 0;
  int quiet_cycles = 0;
  int mismatches = 0;
  int cmds_taken = 0;
  int stored_cnt = 0;
  int refused_cnt = 0;
  int replaced_cnt = 0;
  int popped_cnt[4] = '{0, 0, 0, 0};
  int cap_settings = 0;

  priority_outbound_frame_queue u_top (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .command        (command),
    .msg_type       (msg_type),
    .hold_or_reset  (hold_or_reset),
    .frame_tag      (frame_tag),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .accepted       (accepted),
    .slot_overwrite (slot_overwrite),
    .fatal          (fatal),
    .popped_valid   (popped_valid),
    .popped_tag     (popped_tag),
    .popped_class   (popped_class),
    .occupancy      (occupancy)
  );

  always #5 clk = ~clk;

  // idle length: mostly none, some short, a few long, with quiet stretches
  function automatic int pick_gap(inout int quiet);
    int r;
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      quiet = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(15, 40);
  endfunction

  // expected result of one command, updates the queue model
  function automatic frame_resp_t queue_step(input frame_req_t req);
    frame_resp_t r;
    int lim;
    logic urgent;
    r = '0;
    lim = (fifo_limit > DEPTH) ? DEPTH : fifo_limit;
    case (req.command)
      CMD_PUSH: begin
        if (req.msg_type == MSG_STATE) begin
          r.slot_overwrite = state_held;
          state_held = 1'b1;
          state_value = req.frame_tag;
          r.accepted = 1'b1;
        end else if (req.msg_type == MSG_MAP) begin
          r.slot_overwrite = map_held;
          map_held = 1'b1;
          map_value = req.frame_tag;
          r.accepted = 1'b1;
        end else begin
          urgent = (req.msg_type == MSG_ERROR) ||
                   (req.msg_type == MSG_CONTROL && req.hold_or_reset);
          if (urg_tags.size() + rel_tags.size() >= lim) begin
            r.fatal = 1'b1;
          end else begin
            if (urgent) urg_tags.insert(urg_tags.size(), req.frame_tag);
            else rel_tags.insert(rel_tags.size(), req.frame_tag);
            r.accepted = 1'b1;
          end
        end
      end
      CMD_POP: begin
        if (urg_tags.size() > 0) begin
          r.popped_tag = urg_tags[0];
          urg_tags.delete(0);
          r.popped_class = CLS_URGENT;
          r.popped_valid = 1'b1;
        end else if (rel_tags.size() > 0) begin
          r.popped_tag = rel_tags[0];
          rel_tags.delete(0);
          r.popped_class = CLS_RELIABLE;
          r.popped_valid = 1'b1;
        end else if (state_held) begin
          r.popped_tag = state_value;
          r.popped_class = CLS_STATE;
          r.popped_valid = 1'b1;
          state_held = 1'b0;
          state_value = '0;
        end else if (map_held) begin
          r.popped_tag = map_value;
          r.popped_class = CLS_MAP;
          r.popped_valid = 1'b1;
          map_held = 1'b0;
          map_value = '0;
        end
      end
      CMD_CLEAR: begin
        urg_tags.delete();
        rel_tags.delete();
        state_held = 1'b0;
        state_value = '0;
        map_held = 1'b0;
        map_value = '0;
      end
      default: ;
    endcase
    r.occupancy = 5'(urg_tags.size() + rel_tags.size() + state_held + map_held);
    return r;
  endfunction

  function automatic frame_req_t random_cmd(input int push_pct);
    frame_req_t c;
    int r;
    r = $urandom_range(0, 99);
    if (r < push_pct) c.command = CMD_PUSH;
    else if (r < 97) c.command = CMD_POP;
    else if (r < 99) c.command = CMD_CLEAR;
    else c.command = CMD_SPARE;
    r = $urandom_range(0, 99);
    if (r < 25) c.msg_type = MSG_ERROR;
    else if (r < 45) c.msg_type = MSG_CONTROL;
    else if (r < 58) c.msg_type = MSG_STATE;
    else if (r < 70) c.msg_type = MSG_MAP;
    else if (r < 82) c.msg_type = MSG_OTHER;
    else c.msg_type = 3'($urandom_range(5, 7));
    c.hold_or_reset = 1'($urandom_range(0, 1));
    r = $urandom_range(0, 31);
    if (r == 0) c.frame_tag = '0;
    else if (r == 1) c.frame_tag = '1;
    else c.frame_tag = $urandom;
    return c;
  endfunction

  task automatic add_cmd(input logic [1:0] cmd, input logic [2:0] msg, input logic hold,
                         input logic [31:0] tag);
    frame_req_t c;
    c.command = cmd;
    c.msg_type = msg;
    c.hold_or_reset = hold;
    c.frame_tag = tag;
    cmd_pending.insert(cmd_pending.size(), c);
  endtask

  // block the sender until everything sent has come back
  task automatic wait_idle();
    do @(negedge clk);
    while (cmd_pending.size() != 0 || in_valid || resp_expected.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_capacity(input logic [CAP_W-1:0] v);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data <= v;
    fifo_limit = int'(v);
    cap_settings++;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  // driver: one command word at a time from the pending queue
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        resp_expected.insert(resp_expected.size(), queue_step(cmd_cur));
        cmds_taken++;
      end
      if (!(in_valid && in_stall)) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (cmd_pending.size() > 0) begin
          cmd_cur = cmd_pending[0];
          cmd_pending.delete(0);
          in_valid <= 1'b1;
          command <= cmd_cur.command;
          msg_type <= cmd_cur.msg_type;
          hold_or_reset <= cmd_cur.hold_or_reset;
          frame_tag <= cmd_cur.frame_tag;
          send_gap = pick_gap(send_quiet);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  // monitor: compare each result word with the oldest expectation
  always @(posedge clk) begin
    frame_resp_t want;
    if (rst) begin
      out_stall <= 1'b0;
      quiet_cycles = 0;
    end else begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (out_valid && !out_stall) begin
        if (resp_expected.size() == 0) begin
          $error("result word with no command outstanding");
          mismatches++;
        end else begin
          want = resp_expected[0];
          resp_expected.delete(0);
          check_field("accepted", 32'(want.accepted), 32'(accepted));
          check_field("slot_overwrite", 32'(want.slot_overwrite), 32'(slot_overwrite));
          check_field("fatal", 32'(want.fatal), 32'(fatal));
          check_field("popped_valid", 32'(want.popped_valid), 32'(popped_valid));
          check_field("popped_tag", want.popped_tag, popped_tag);
          check_field("popped_class", 32'(want.popped_class), 32'(popped_class));
          check_field("occupancy", 32'(want.occupancy), 32'(occupancy));
          stored_cnt += int'(want.accepted);
          refused_cnt += int'(want.fatal);
          replaced_cnt += int'(want.slot_overwrite);
          if (want.popped_valid) popped_cnt[want.popped_class]++;
        end
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        stall_left = pick_gap(stall_quiet);
      end
    end
  end

  // watchdog on a stuck handshake
  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
    $display("FAIL");
    $finish;
  end

  initial begin
    int caps[10];
    caps = '{16, 31, 0, 1, 3, 17, 8, 31, 16, 0};
    caps[9] = $urandom_range(0, 31);
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: slots, priority order, spare codes, clear
    add_cmd(CMD_POP, MSG_ERROR, 1'b0, 32'h0);
    add_cmd(CMD_PUSH, MSG_STATE, 1'b0, 32'h0000_0000);
    add_cmd(CMD_PUSH, MSG_STATE, 1'b1, 32'hffff_ffff);
    add_cmd(CMD_PUSH, MSG_MAP, 1'b0, 32'h1234_5678);
    add_cmd(CMD_PUSH, MSG_MAP, 1'b1, 32'ha5a5_a5a5);
    add_cmd(CMD_PUSH, MSG_ERROR, 1'b0, 32'h0000_0001);
    add_cmd(CMD_PUSH, MSG_CONTROL, 1'b1, 32'h0000_0002);
    add_cmd(CMD_PUSH, MSG_CONTROL, 1'b0, 32'h0000_0003);
    add_cmd(CMD_PUSH, MSG_OTHER, 1'b1, 32'h0000_0004);
    add_cmd(CMD_PUSH, 3'd7, 1'b1, 32'h0000_0005);
    add_cmd(CMD_PUSH, 3'd5, 1'b0, 32'h0000_0006);
    add_cmd(CMD_PUSH, MSG_ERROR, 1'b1, 32'h8000_0007);
    add_cmd(CMD_SPARE, 3'd7, 1'b1, 32'hffff_ffff);
    repeat (10) add_cmd(CMD_POP, 3'd7, 1'b1, 32'hffff_ffff);
    add_cmd(CMD_PUSH, 3'd6, 1'b0, 32'hdead_beef);
    add_cmd(CMD_PUSH, MSG_STATE, 1'b0, 32'h5555_aaaa);
    add_cmd(CMD_CLEAR, MSG_MAP, 1'b1, 32'h0);
    add_cmd(CMD_POP, MSG_ERROR, 1'b0, 32'h0);
    wait_idle();

    // zero capacity refuses every fifo push, slots still take frames
    set_capacity(5'd0);
    add_cmd(CMD_PUSH, MSG_ERROR, 1'b0, 32'h0bad_0001);
    add_cmd(CMD_PUSH, MSG_OTHER, 1'b0, 32'h0bad_0002);
    add_cmd(CMD_PUSH, MSG_MAP, 1'b0, 32'h0bad_0003);
    add_cmd(CMD_POP, MSG_ERROR, 1'b0, 32'h0);
    wait_idle();

    // random phases, alternating fill-heavy and drain-heavy traffic
    for (int p = 0; p < 10; p++) begin
      set_capacity(5'(caps[p]));
      repeat (110) cmd_pending.insert(cmd_pending.size(),
                                      random_cmd((p % 2 == 0) ? 75 : 45));
      wait_idle();
    end

    repeat (10) @(negedge clk);
    $display("%0d commands over %0d capacity settings: %0d stored, %0d refused, %0d overwrites",
             cmds_taken, cap_settings, stored_cnt, refused_cnt, replaced_cnt);
    $display("pops served: urgent %0d, reliable %0d, state %0d, map %0d",
             popped_cnt[0], popped_cnt[1], popped_cnt[2], popped_cnt[3]);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
